>>> rtl/nnbs_pkg.sv
// nnbs_pkg: shared widths, defaults and register map of the nearest neighbor scaler
// no dependencies; imported by the top level and its checker

package nnbs_pkg;

    // payload and register widths
    localparam int COORD_W    = 12;
    localparam int PIXEL_W    = 32;
    localparam int SRC_SIZE_W = 9;
    localparam int DST_SIZE_W = 13;

    // quotient of one axis is below the source size, so it fits the source size width
    localparam int QUO_W = SRC_SIZE_W;
    // dividend and shifted divisor width of the shared divide unit
    localparam int REM_W = DST_SIZE_W + SRC_SIZE_W;
    localparam int CNT_W = $clog2(QUO_W);

    // configuration port
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int REG_INDEX_W = 2;

    // default store and destination limits
    localparam int DEF_MAX_SRC_WIDTH  = 256;
    localparam int DEF_MAX_SRC_HEIGHT = 256;
    localparam int DEF_MAX_DST_DIM    = 4096;

    // reset values of the size registers
    localparam logic [SRC_SIZE_W-1:0] RST_SRC_SIZE = SRC_SIZE_W'(256);
    localparam logic [DST_SIZE_W-1:0] RST_DST_SIZE = DST_SIZE_W'(256);

    // register map, word index
    typedef enum logic [REG_INDEX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } reg_index_t;

    // input beat function codes
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

endpackage

>>> rtl/nnbs_ram.sv
// nnbs_ram: generic single port RAM with registered read data
// no dependencies; used as the frame store of the scaler

module nnbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write when enabled; read data is registered every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/nearest_neighbor_bgra_scaler.sv
// Nearest neighbor BGRA scaler. A load beat (func low) writes one pixel into the frame store when
// its coordinates lie inside the store and gives no result; busy stays low, so beats can follow
// back to back. For a request beat (func high) one shared 12x9 multiplier and one compare-subtract
// divider produce each source coordinate as a product then its quotient bits, for column then row,
// followed by a frame-store read and the registered read data. A request that fails the size or
// destination range checks answers on the cycle after it is accepted; one whose source coordinate
// lies outside the store is flagged after the read state. Results are shown for exactly one cycle
// with done high; the receiver cannot stall. No reset sweep of the frame store is done, so a new
// request can start right after reset. The user must write the size registers through the APB port
// only while the block is idle; the block does not enforce it. Depends on nnbs_pkg and nnbs_ram.

module nearest_neighbor_bgra_scaler
    import nnbs_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
    parameter int MAX_DST_DIM    = DEF_MAX_DST_DIM
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic [COORD_W-1:0]    coord_x,
    input  logic [COORD_W-1:0]    coord_y,
    input  logic [PIXEL_W-1:0]    load_pixel,
    // result channel
    output logic                  done,
    output logic [PIXEL_W-1:0]    out_pixel,
    output logic                  bad_request,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_READ,
        ST_DATA
    } state_t;

    // size registers
    logic [SRC_SIZE_W-1:0] src_width_reg;
    logic [SRC_SIZE_W-1:0] src_height_reg;
    logic [DST_SIZE_W-1:0] dst_width_reg;
    logic [DST_SIZE_W-1:0] dst_height_reg;

    // sequencer and datapath registers
    state_t                state_reg;
    logic                  axis_reg;
    logic [COORD_W-1:0]    x_reg;
    logic [COORD_W-1:0]    y_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      dsh_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [QUO_W-1:0]      sx_reg;
    logic                  done_reg;
    logic [PIXEL_W-1:0]    out_pixel_reg;
    logic                  bad_reg;

    logic                  accept;
    logic                  cfg_write;
    reg_index_t            reg_index;
    logic                  size_zero;
    logic                  dst_outside;
    logic                  load_in_store;
    logic                  src_outside;
    logic [COORD_W-1:0]    mul_a;
    logic [SRC_SIZE_W-1:0] mul_b;
    logic [DST_SIZE_W-1:0] divisor;
    logic [REM_W-1:0]      product;
    logic                  rem_ge;
    logic [REM_W-1:0]      rem_next;
    logic [QUO_W-1:0]      quo_next;
    logic [ADDR_W-1:0]     load_addr;
    logic [ADDR_W-1:0]     read_addr;
    logic [ADDR_W-1:0]     ram_addr;
    logic                  ram_we;
    logic [PIXEL_W-1:0]    ram_rdata;

    // handshakes
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = reg_index_t'(paddr[REG_INDEX_W+1:2]);

    // size register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= RST_SRC_SIZE;
            src_height_reg <= RST_SRC_SIZE;
            dst_width_reg  <= RST_DST_SIZE;
            dst_height_reg <= RST_DST_SIZE;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[SRC_SIZE_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[SRC_SIZE_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= pwdata[DST_SIZE_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= pwdata[DST_SIZE_W-1:0];
                default:        ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_index)
            REG_SRC_WIDTH:  prdata = APB_DATA_W'(src_width_reg);
            REG_SRC_HEIGHT: prdata = APB_DATA_W'(src_height_reg);
            REG_DST_WIDTH:  prdata = APB_DATA_W'(dst_width_reg);
            REG_DST_HEIGHT: prdata = APB_DATA_W'(dst_height_reg);
            default:        prdata = '0;
        endcase
    end

    // request checks at accept
    assign size_zero = (src_width_reg == '0) || (src_height_reg == '0)
                    || (dst_width_reg == '0) || (dst_height_reg == '0);
    assign dst_outside = (DST_SIZE_W'(coord_x) >= dst_width_reg)
                      || (DST_SIZE_W'(coord_y) >= dst_height_reg)
                      || (32'(coord_x) >= MAX_DST_DIM)
                      || (32'(coord_y) >= MAX_DST_DIM);
    assign load_in_store = (32'(coord_x) < MAX_SRC_WIDTH) && (32'(coord_y) < MAX_SRC_HEIGHT);

    // shared multiplier, one axis at a time
    assign mul_a   = axis_reg ? y_reg : x_reg;
    assign mul_b   = axis_reg ? src_height_reg : src_width_reg;
    assign divisor = axis_reg ? dst_height_reg : dst_width_reg;
    assign product = REM_W'(mul_a * mul_b);

    // shared compare-subtract, one quotient bit per cycle
    assign rem_ge   = (rem_reg >= dsh_reg);
    assign rem_next = rem_ge ? (rem_reg - dsh_reg) : rem_reg;
    assign quo_next = {quo_reg[QUO_W-2:0], rem_ge};

    // source coordinate against the store
    assign src_outside = (32'(sx_reg) >= MAX_SRC_WIDTH) || (32'(quo_reg) >= MAX_SRC_HEIGHT);

    // dense store addressing, row major
    assign load_addr = ADDR_W'(32'(coord_y) * MAX_SRC_WIDTH + 32'(coord_x));
    assign read_addr = ADDR_W'(32'(quo_reg) * MAX_SRC_WIDTH + 32'(sx_reg));
    assign ram_addr  = (state_reg == ST_READ) ? read_addr : load_addr;
    assign ram_we    = accept && (func == FUNC_LOAD) && load_in_store;

    // sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            done_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            out_pixel_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (func == FUNC_REQUEST))
                    begin
                        if (size_zero || dst_outside)
                        begin
                            done_reg      <= 1'b1;
                            bad_reg       <= 1'b1;
                            out_pixel_reg <= '0;
                        end
                        else
                        begin
                            x_reg     <= coord_x;
                            y_reg     <= coord_y;
                            axis_reg  <= 1'b0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    rem_reg   <= product;
                    dsh_reg   <= REM_W'(divisor) << (QUO_W - 1);
                    quo_reg   <= '0;
                    cnt_reg   <= CNT_W'(QUO_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg <= rem_next;
                    dsh_reg <= dsh_reg >> 1;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        if (!axis_reg)
                        begin
                            sx_reg    <= quo_next;
                            axis_reg  <= 1'b1;
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    if (src_outside)
                    begin
                        done_reg      <= 1'b1;
                        bad_reg       <= 1'b1;
                        out_pixel_reg <= '0;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    done_reg      <= 1'b1;
                    bad_reg       <= 1'b0;
                    out_pixel_reg <= ram_rdata;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign bad_request = bad_reg;
    assign out_pixel   = out_pixel_reg;

    // frame store
    nnbs_ram #(
        .WIDTH  (PIXEL_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (load_pixel),
        .rdata (ram_rdata)
    );

endmodule

>>> rtl/nnbs_checker.sv
// nnbs_checker: port-level assertions for the nearest neighbor scaler
// depends on nnbs_pkg; bound to nearest_neighbor_bgra_scaler at the end of this file

module nnbs_checker
    import nnbs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  func,
    input logic                  done,
    input logic [PIXEL_W-1:0]    out_pixel,
    input logic                  bad_request,
    input logic                  pready
);

    // a load beat never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_LOAD)) |=> !done)
        else $error("result after a load beat");

    // a request beat either answers at once or keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_REQUEST)) |=> (busy || done))
        else $error("request beat dropped");

    // a flagged result carries a zero pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_request) |-> (out_pixel == '0))
        else $error("flagged result with nonzero pixel");

    // a served pixel comes only after a busy phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !bad_request) |-> $past(busy))
        else $error("served pixel without a lookup");

    // the configuration port never waits
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind nearest_neighbor_bgra_scaler nnbs_checker u_nnbs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .done        (done),
    .out_pixel   (out_pixel),
    .bad_request (bad_request),
    .pready      (pready)
);
